// ===== src/sis_pkg.sv =====
// Package for the sorted id set: payload structs, operation codes, sizes.
// No dependencies.
package sis_pkg;
    localparam int CAPACITY = 64;
    localparam int ID_BITS = 32;
    localparam int IDX_BITS = $clog2(CAPACITY);
    localparam int CNT_BITS = $clog2(CAPACITY + 1);

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;
    localparam logic [1:0] OP_NOP = 2'd3;

    typedef struct packed {
        logic [1:0] operation;
        logic [ID_BITS-1:0] id;
    } sis_in_t;

    typedef struct packed {
        logic changed;
        logic present;
        logic [5:0] position;
        logic full_error;
        logic [6:0] count;
    } sis_out_t;

    typedef struct packed {
        logic load;
        logic commit;
    } sis_cmd_t;
endpackage

// ===== src/sis_datapath.sv =====
// Datapath for the sorted id set: the cell row, compare, and shift logic.
// Depends on sis_pkg.
module sis_datapath import sis_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  sis_cmd_t cmd,
    input  sis_in_t  in_beat,
    output sis_out_t result
);
    logic [ID_BITS-1:0] cell_reg [CAPACITY];
    logic [CNT_BITS-1:0] count_reg, count_next;
    sis_in_t item_reg;
    logic [CAPACITY-1:0] less_reg, equal_reg;
    logic [CAPACITY-1:0] less_w, equal_w;
    logic [CNT_BITS-1:0] lb;
    logic present, do_add, do_rem, full;
    logic [IDX_BITS-1:0] idx;

    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            less_w[k] = (CNT_BITS'(k) < count_reg) && (cell_reg[k] < in_beat.id);
            equal_w[k] = (CNT_BITS'(k) < count_reg) && (cell_reg[k] == in_beat.id);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= in_beat;
            less_reg <= less_w;
            equal_reg <= equal_w;
        end
    end

    always_comb begin
        lb = CNT_BITS'($countones(less_reg));
        idx = lb[IDX_BITS-1:0];
        present = |equal_reg;
        full = (count_reg == CNT_BITS'(CAPACITY));
        do_add = (item_reg.operation == OP_ADD) && !present && !full;
        do_rem = (item_reg.operation == OP_REMOVE) && present;
        count_next = count_reg;
        if (do_add) begin
            count_next = count_reg + 1'b1;
        end else if (do_rem) begin
            count_next = count_reg - 1'b1;
        end
        result.changed = do_add || do_rem;
        result.present = present && (item_reg.operation != OP_NOP);
        result.full_error = (item_reg.operation == OP_ADD) && !present && full;
        result.position = ((item_reg.operation != OP_NOP) && (present || do_add))
                          ? 6'(idx) : 6'd0;
        result.count = 7'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            for (int k = 0; k < CAPACITY; k++) begin
                if (do_add) begin
                    if (CNT_BITS'(k) == lb) begin
                        cell_reg[k] <= item_reg.id;
                    end else if (CNT_BITS'(k) > lb && k > 0) begin
                        cell_reg[k] <= cell_reg[(k + CAPACITY - 1) % CAPACITY];
                    end
                end else if (do_rem) begin
                    if (CNT_BITS'(k) >= lb && k < CAPACITY - 1) begin
                        cell_reg[k] <= cell_reg[(k + 1) % CAPACITY];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.commit) begin
            count_reg <= count_next;
        end
    end
endmodule

// ===== src/sis_ctrl.sv =====
// Controller for the sorted id set: accept, compare, commit and output hold.
// Depends on sis_pkg.
module sis_ctrl import sis_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output sis_cmd_t cmd
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_OUT = 2'd2;

    logic [1:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        s_ready = 1'b0;
        m_valid = 1'b0;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                cmd.load = s_valid;
                if (s_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                cmd.commit = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

// ===== src/sorted_id_set.sv =====
// Top level of the sorted id set: controller, datapath and output register.
// Depends on sis_pkg, sis_ctrl and sis_datapath.
// Holds up to 64 distinct 32-bit ids in ascending order. Each input beat adds,
// removes or searches one id, or is a no-op; one result beat follows. All cells
// compare in the accept cycle and shift in the next, and the result is then
// offered from the output register. The input is ready again the cycle after the
// result is taken, so one item is worked at a time.
module sorted_id_set import sis_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sis_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output sis_out_t m_data
);
    sis_cmd_t cmd;
    sis_out_t result;
    sis_out_t out_reg;

    sis_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .cmd(cmd)
    );

    sis_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .in_beat(s_data), .result(result)
    );

    always_ff @(posedge aclk) begin
        if (cmd.commit) out_reg <= result;
    end
    assign m_data = out_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.count <= 7'(CAPACITY)) else $error("count out of range");
    a_full_nochange: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.full_error |-> !m_data.changed) else $error("full changed");
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("accept during output");
endmodule

// ===== tb/sv/sorted_id_set_test.sv =====
// Testbench for sorted_id_set: directed table plus random add/remove/search/no-op beats,
// checked against a behavioral sorted-set predictor. Depends on sis_pkg and the RTL.
`timescale 1ns / 100ps

module sorted_id_set_test;
    import sis_pkg::*;

    localparam int MAX_CYCLES = 400000;

    typedef struct {
        sis_in_t  beat;
        logic     has_result;
        sis_out_t result;
    } table_row_t;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    sis_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    sis_out_t m_data;

    logic [ID_BITS-1:0] set_ids[$];
    sis_out_t expected_results[$];
    int errors = 0;
    int check_errors = 0;
    int cycles = 0;
    int sent = 0;
    int received = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit long_hold = 1'b0;

    sorted_id_set dut (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic sis_out_t apply_set_op(sis_in_t beat);
        sis_out_t r;
        int idx;
        bit hit;
        r = '0;
        idx = 0;
        while (idx < set_ids.size() && set_ids[idx] < beat.id) idx++;
        hit = (idx < set_ids.size()) && (set_ids[idx] == beat.id);
        case (beat.operation)
            OP_ADD: begin
                r.present = hit;
                if (hit) begin
                    r.position = idx[5:0];
                end else if (set_ids.size() >= CAPACITY) begin
                    r.full_error = 1'b1;
                end else begin
                    set_ids.insert(idx, beat.id);
                    r.changed = 1'b1;
                    r.position = idx[5:0];
                end
            end
            OP_REMOVE: begin
                r.present = hit;
                if (hit) begin
                    set_ids.delete(idx);
                    r.changed = 1'b1;
                    r.position = idx[5:0];
                end
            end
            OP_SEARCH: begin
                r.present = hit;
                if (hit) r.position = idx[5:0];
            end
            default: ;
        endcase
        r.count = 7'(set_ids.size());
        return r;
    endfunction

    function automatic logic [ID_BITS-1:0] pick_id();
        int k;
        k = $urandom_range(0, 99);
        if (set_ids.size() > 0 && k < 45) return set_ids[$urandom_range(0, set_ids.size() - 1)];
        if (k < 85) return $urandom_range(0, 200);
        return $urandom;
    endfunction

    task automatic send_beat(sis_in_t beat);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_data <= beat;
        s_valid <= 1'b1;
        expected_results.push_back(apply_set_op(beat));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_results.size() > 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYCLES) begin
            $display("Timeout at %0t after %0d cycles", $time, cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                received <= received + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, m_data);
                    errors <= errors + 1;
                end else begin
                    sis_out_t e;
                    e = expected_results.pop_front();
                    if (m_data !== e) begin
                        $display("%0t: mismatch expected %p actual %p", $time, e, m_data);
                        errors <= errors + 1;
                    end
                end
            end
            if (long_hold) m_ready <= 1'b0;
            else if (recv_stall_pct > 0) m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            else m_ready <= 1'b1;
        end
    end

    initial begin
        table_row_t rows[$];
        table_row_t row;
        sis_in_t b;
        int phase;
        int n;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        rows.push_back('{'{OP_SEARCH, 32'd5}, 1'b1, '{1'b0, 1'b0, 6'd0, 1'b0, 7'd0}});
        rows.push_back('{'{OP_REMOVE, 32'd5}, 1'b1, '{1'b0, 1'b0, 6'd0, 1'b0, 7'd0}});
        rows.push_back('{'{OP_NOP, 32'd5}, 1'b1, '{1'b0, 1'b0, 6'd0, 1'b0, 7'd0}});
        rows.push_back('{'{OP_ADD, 32'hFFFF_FFFF}, 1'b1, '{1'b1, 1'b0, 6'd0, 1'b0, 7'd1}});
        rows.push_back('{'{OP_ADD, 32'h0}, 1'b1, '{1'b1, 1'b0, 6'd0, 1'b0, 7'd2}});
        rows.push_back('{'{OP_ADD, 32'hFFFF_FFFF}, 1'b1, '{1'b0, 1'b1, 6'd1, 1'b0, 7'd2}});
        rows.push_back('{'{OP_ADD, 32'h8000_0000}, 1'b0, '0});
        rows.push_back('{'{OP_SEARCH, 32'hFFFF_FFFF}, 1'b0, '0});
        rows.push_back('{'{OP_SEARCH, 32'h7FFF_FFFF}, 1'b0, '0});
        rows.push_back('{'{OP_NOP, 32'h0}, 1'b0, '0});
        rows.push_back('{'{OP_REMOVE, 32'h8000_0000}, 1'b0, '0});
        rows.push_back('{'{OP_REMOVE, 32'h0}, 1'b0, '0});
        rows.push_back('{'{OP_REMOVE, 32'hFFFF_FFFF}, 1'b0, '0});
        rows.push_back('{'{OP_REMOVE, 32'hFFFF_FFFF}, 1'b0, '0});
        set_ids.delete();
        foreach (rows[i]) begin
            row = rows[i];
            send_beat(row.beat);
            if (row.has_result && expected_results[$] !== row.result) begin
                $display("%0t: table row %0d expected %p, predictor %p", $time, i,
                         row.result, expected_results[$]);
                check_errors++;
            end
        end
        drain();

        // Fill to capacity, hit the full case, then search for the refused id.
        for (int k = 0; k < CAPACITY; k++) begin
            b.operation = OP_ADD;
            b.id = (k * 7919) ^ 32'hA5A5_0000;
            send_beat(b);
        end
        b.operation = OP_ADD;
        b.id = 32'h1234_5678;
        send_beat(b);
        if (expected_results[$].full_error !== 1'b1) begin
            $display("%0t: full store not flagged, expected 1 actual 0", $time);
            check_errors++;
        end
        b.operation = OP_SEARCH;
        send_beat(b);
        drain();

        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct = (phase == 1 || phase == 3) ? (phase == 3 ? 19 : 56) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 3 ? 19 : 56) : 0;
            if (phase == 0) begin
                long_hold = 1'b1;
                fork
                    begin
                        repeat (60) @(posedge aclk);
                        long_hold = 1'b0;
                    end
                join_none
            end
            for (n = 0; n < 375; n++) begin
                b.operation = ($urandom_range(0, 99) < 3) ? OP_NOP : 2'($urandom_range(0, 2));
                if (set_ids.size() > 56 && b.operation == OP_ADD && $urandom_range(0, 1))
                    b.operation = OP_REMOVE;
                b.id = pick_id();
                send_beat(b);
            end
            drain();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        $display("Ran %0d beats: directed extremes, full store, four idle/stall phases.",
                 sent);
        $display("Results checked: %0d, errors: %0d", received, errors + check_errors);
        if (errors + check_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
